@@ src/tps_pkg.sv @@
package tps_pkg;

  // Plane depth is a power of two, so a read address wraps by dropping high bits.
  localparam int MAX_PLANE_CELLS = 4096;
  localparam int VEL_WIDTH       = 16;
  localparam int ADDR_W          = $clog2(MAX_PLANE_CELLS);

  localparam int LEN_W   = 31;
  localparam int CNT_W   = 7;
  localparam int POS_W   = 32;
  localparam int ENTRY_W = 12;
  localparam int FRAC_W  = 16;
  localparam int WGT_W   = FRAC_W + 1;
  localparam int MUL_W   = 2 * WGT_W;
  localparam int CIDX_W  = 3;

  // Remainder unit: one quotient bit per stage over the full position word.
  localparam int DIV_STEPS = POS_W;

  localparam int SMP_W   = 3 * VEL_WIDTH;
  localparam int PROD_W  = VEL_WIDTH + WGT_W + 1;
  localparam int SUM_W   = PROD_W + 3;
  localparam int RND_W   = SUM_W - FRAC_W;

  localparam logic [WGT_W-1:0] WGT_ONE  = WGT_W'(1) << FRAC_W;
  localparam logic [MUL_W-1:0] RND_HALF = MUL_W'(1) << (FRAC_W - 1);
  localparam logic [LEN_W-1:0] LEN_RST  = LEN_W'(65536);
  localparam logic [CNT_W-1:0] CNT_RST  = CNT_W'(64);

  typedef logic signed [VEL_WIDTH-1:0] vel_t;

  typedef enum logic [CIDX_W-1:0] {
    CFG_LEN_X      = 3'd0,
    CFG_LEN_Y      = 3'd1,
    CFG_LEN_Z      = 3'd2,
    CFG_INV_CELL_X = 3'd3,
    CFG_INV_CELL_Y = 3'd4,
    CFG_INV_CELL_Z = 3'd5,
    CFG_CELLS_Y    = 3'd6,
    CFG_CELLS_Z    = 3'd7
  } cfg_idx_e;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_SAMPLE = 1'b1
  } op_e;

  // What every item carries down the pipeline besides its arithmetic.
  typedef struct packed {
    logic                  smp;
    logic                  plane;
    logic [ENTRY_W-1:0]    entry;
    logic [SMP_W-1:0]      wdata;
    logic                  oob;
  } item_t;

  typedef struct packed {
    item_t              it;
    logic [FRAC_W-1:0]  fy;
    logic [FRAC_W-1:0]  fz;
    logic [POS_W-1:0]   ax;
    logic               xneg;
    logic [POS_W-1:0]   qy;
    logic [POS_W-1:0]   qz;
    logic [LEN_W-1:0]   rx;
    logic [CNT_W-1:0]   ry;
    logic [CNT_W-1:0]   rz;
  } div_t;

endpackage

@@ src/tps_ram.sv @@
module tps_ram #(
  parameter int Width = 48,
  parameter int Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [Width-1:0]         rdata_a_o,
  output logic [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_a_q;
  logic [Width-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

@@ src/turbulence_plane_sampler.sv @@
// Two-plane periodic velocity sampler. Write beats (op 0) store one u/v/w
// sample into plane 0 or 1 at entry_index; sample beats (op 1) give a point
// (pos_y, pos_z) measured from the box center and a streamwise travel pos_x,
// and return one result: out_of_box, or the trilinear blend of the eight
// surrounding samples (four per plane, planes blended by the streamwise
// fraction), rounded to Q5.10 and saturated. Write beats return nothing.
// The block takes one beat every cycle unless an output stall holds it back.
// Each beat passes through 40 register stages. That depth is set by the
// streamwise remainder (pos_x modulo len_x) and the two lateral/vertical
// index remainders, which resolve one bit per stage over 32 stages. A
// stall on the output holds the whole pipeline in place.
// Each plane sits in two dual-read RAM copies so that all eight corners are
// read in the same cycle; writes go to both copies of a plane in pipeline
// order, so a sample always sees every write accepted before it.
// Configuration is taken at any time but must only change while idle.
module turbulence_plane_sampler (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            op_i,
  input  logic                            plane_i,
  input  logic [tps_pkg::ENTRY_W-1:0]     entry_index_i,
  input  tps_pkg::vel_t                   u_in_i,
  input  tps_pkg::vel_t                   v_in_i,
  input  tps_pkg::vel_t                   w_in_i,
  input  logic signed [tps_pkg::POS_W-1:0] pos_x_i,
  input  logic signed [tps_pkg::POS_W-1:0] pos_y_i,
  input  logic signed [tps_pkg::POS_W-1:0] pos_z_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            out_of_box_o,
  output tps_pkg::vel_t                   u_out_o,
  output tps_pkg::vel_t                   v_out_o,
  output tps_pkg::vel_t                   w_out_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [tps_pkg::CIDX_W-1:0]      cfg_index_i,
  input  logic [tps_pkg::LEN_W-1:0]       cfg_data_i
);
  import tps_pkg::*;

  // Configuration registers.
  logic [LEN_W-1:0] len_x_q, len_y_q, len_z_q;
  logic [LEN_W-1:0] inv_x_q, inv_y_q, inv_z_q;
  logic [CNT_W-1:0] cells_y_q, cells_z_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_x_q   <= LEN_RST;
      len_y_q   <= LEN_RST;
      len_z_q   <= LEN_RST;
      inv_x_q   <= LEN_RST;
      inv_y_q   <= LEN_RST;
      inv_z_q   <= LEN_RST;
      cells_y_q <= CNT_RST;
      cells_z_q <= CNT_RST;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_LEN_X:      len_x_q   <= cfg_data_i;
        CFG_LEN_Y:      len_y_q   <= cfg_data_i;
        CFG_LEN_Z:      len_z_q   <= cfg_data_i;
        CFG_INV_CELL_X: inv_x_q   <= cfg_data_i;
        CFG_INV_CELL_Y: inv_y_q   <= cfg_data_i;
        CFG_INV_CELL_Z: inv_z_q   <= cfg_data_i;
        CFG_CELLS_Y:    cells_y_q <= cfg_data_i[CNT_W-1:0];
        CFG_CELLS_Z:    cells_z_q <= cfg_data_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // A zero length or cell count behaves as one.
  logic [LEN_W-1:0] lx, ly, lz;
  logic [CNT_W-1:0] ny, nz;
  assign lx = (len_x_q == '0) ? LEN_W'(1) : len_x_q;
  assign ly = (len_y_q == '0) ? LEN_W'(1) : len_y_q;
  assign lz = (len_z_q == '0) ? LEN_W'(1) : len_z_q;
  assign ny = (cells_y_q == '0) ? CNT_W'(1) : cells_y_q;
  assign nz = (cells_z_q == '0) ? CNT_W'(1) : cells_z_q;

  // The whole pipeline moves together unless a finished result is stalled.
  logic adv;
  logic out_valid_q;
  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = !adv;

  // Stage 1: box test and the absolute streamwise travel.
  logic signed [POS_W:0] cy, cz;
  logic                  oob_y, oob_z;
  logic [LEN_W-1:0]      py_d, pz_d;
  logic [POS_W-1:0]      ax_d;
  item_t                 it_d;

  always_comb begin
    cy    = $signed({pos_y_i[POS_W-1], pos_y_i}) + $signed({2'b00, ly[LEN_W-1:1]});
    cz    = $signed({pos_z_i[POS_W-1], pos_z_i}) + $signed({2'b00, lz[LEN_W-1:1]});
    oob_y = cy[POS_W] || (cy[POS_W-1:0] > {1'b0, ly});
    oob_z = cz[POS_W] || (cz[POS_W-1:0] > {1'b0, lz});
    py_d  = (cy[POS_W-1:0] == {1'b0, ly}) ? '0 : cy[LEN_W-1:0];
    pz_d  = (cz[POS_W-1:0] == {1'b0, lz}) ? '0 : cz[LEN_W-1:0];
    ax_d  = pos_x_i[POS_W-1] ? POS_W'(-pos_x_i) : POS_W'(pos_x_i);
    it_d.smp   = (op_e'(op_i) == OP_SAMPLE);
    it_d.plane = plane_i;
    it_d.entry = entry_index_i;
    it_d.wdata = {u_in_i, v_in_i, w_in_i};
    it_d.oob   = oob_y || oob_z;
  end

  logic             s1_vld_q;
  item_t            s1_it_q;
  logic [LEN_W-1:0] s1_py_q, s1_pz_q;
  logic [POS_W-1:0] s1_ax_q;
  logic             s1_xneg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_it_q   <= it_d;
      s1_py_q   <= py_d;
      s1_pz_q   <= pz_d;
      s1_ax_q   <= ax_d;
      s1_xneg_q <= pos_x_i[POS_W-1];
    end
  end

  // Stage 2: position times reciprocal cell size for the lateral and
  // vertical axes. The integer part feeds the index remainder, bits 31..16
  // are the fraction.
  logic [2*LEN_W-1:0] my, mz;
  div_t               dv_d;
  div_t               dv_q   [DIV_STEPS+1];
  logic               dv_vld_q [DIV_STEPS+1];

  always_comb begin
    my        = (2*LEN_W)'(s1_py_q) * (2*LEN_W)'(inv_y_q);
    mz        = (2*LEN_W)'(s1_pz_q) * (2*LEN_W)'(inv_z_q);
    dv_d.it   = s1_it_q;
    dv_d.fy   = my[2*FRAC_W-1:FRAC_W];
    dv_d.fz   = mz[2*FRAC_W-1:FRAC_W];
    dv_d.ax   = s1_ax_q;
    dv_d.xneg = s1_xneg_q;
    dv_d.qy   = POS_W'(my[2*LEN_W-1:POS_W]);
    dv_d.qz   = POS_W'(mz[2*LEN_W-1:POS_W]);
    dv_d.rx   = '0;
    dv_d.ry   = '0;
    dv_d.rz   = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_vld_q[0] <= 1'b0;
    end else if (adv) begin
      dv_vld_q[0] <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dv_q[0] <= dv_d;
    end
  end

  // Restoring remainder stages, most significant dividend bit first. The
  // streamwise lane divides by len_x, the index lanes by the cell counts.
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    logic [POS_W-1:0] tx;
    logic [CNT_W:0]   ty, tz;
    div_t             nxt;

    always_comb begin
      nxt = dv_q[k];
      tx  = {dv_q[k].rx, dv_q[k].ax[DIV_STEPS-1-k]};
      if (tx >= {1'b0, lx}) begin
        tx = tx - {1'b0, lx};
      end
      ty = {dv_q[k].ry, dv_q[k].qy[DIV_STEPS-1-k]};
      if (ty >= {1'b0, ny}) begin
        ty = ty - {1'b0, ny};
      end
      tz = {dv_q[k].rz, dv_q[k].qz[DIV_STEPS-1-k]};
      if (tz >= {1'b0, nz}) begin
        tz = tz - {1'b0, nz};
      end
      nxt.rx = tx[LEN_W-1:0];
      nxt.ry = ty[CNT_W-1:0];
      nxt.rz = tz[CNT_W-1:0];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_vld_q[k+1] <= 1'b0;
      end else if (adv) begin
        dv_vld_q[k+1] <= dv_vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        dv_q[k+1] <= nxt;
      end
    end
  end

  // Stage 3: floored streamwise position and the right-hand cell indices.
  div_t             dl;
  logic [LEN_W-1:0] px_d;
  logic [CNT_W:0]   jn, kn;
  logic [CNT_W-1:0] jr_d, kr_d;

  always_comb begin
    dl   = dv_q[DIV_STEPS];
    px_d = (dl.xneg && (dl.rx != '0)) ? (lx - dl.rx) : dl.rx;
    jn   = {1'b0, dl.ry} + (CNT_W+1)'(1);
    kn   = {1'b0, dl.rz} + (CNT_W+1)'(1);
    jr_d = (jn >= {1'b0, ny}) ? '0 : jn[CNT_W-1:0];
    kr_d = (kn >= {1'b0, nz}) ? '0 : kn[CNT_W-1:0];
  end

  logic              s3_vld_q;
  item_t             s3_it_q;
  logic [FRAC_W-1:0] s3_fy_q, s3_fz_q;
  logic [LEN_W-1:0]  s3_px_q;
  logic [CNT_W-1:0]  s3_jl_q, s3_jr_q, s3_kl_q, s3_kr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else if (adv) begin
      s3_vld_q <= dv_vld_q[DIV_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_it_q <= dl.it;
      s3_fy_q <= dl.fy;
      s3_fz_q <= dl.fz;
      s3_px_q <= px_d;
      s3_jl_q <= dl.ry;
      s3_jr_q <= jr_d;
      s3_kl_q <= dl.rz;
      s3_kr_q <= kr_d;
    end
  end

  // Stage 4: streamwise fraction, corner addresses and lateral-vertical
  // weights. Corners run (left,left), (right,left), (right,right),
  // (left,right) in (y,z).
  localparam int IDX_W = 2 * CNT_W;

  logic [2*LEN_W-1:0] mx;
  logic [IDX_W-1:0]   lin [4];
  logic [WGT_W-1:0]   yl, yr, zl, zr;
  logic [MUL_W-1:0]   wp  [4];

  always_comb begin
    mx     = (2*LEN_W)'(s3_px_q) * (2*LEN_W)'(inv_x_q);
    lin[0] = IDX_W'(s3_jl_q) * IDX_W'(nz) + IDX_W'(s3_kl_q);
    lin[1] = IDX_W'(s3_jr_q) * IDX_W'(nz) + IDX_W'(s3_kl_q);
    lin[2] = IDX_W'(s3_jr_q) * IDX_W'(nz) + IDX_W'(s3_kr_q);
    lin[3] = IDX_W'(s3_jl_q) * IDX_W'(nz) + IDX_W'(s3_kr_q);
    yl     = WGT_ONE - {1'b0, s3_fy_q};
    yr     = {1'b0, s3_fy_q};
    zl     = WGT_ONE - {1'b0, s3_fz_q};
    zr     = {1'b0, s3_fz_q};
    wp[0]  = MUL_W'(yl) * MUL_W'(zl) + RND_HALF;
    wp[1]  = MUL_W'(yr) * MUL_W'(zl) + RND_HALF;
    wp[2]  = MUL_W'(yr) * MUL_W'(zr) + RND_HALF;
    wp[3]  = MUL_W'(yl) * MUL_W'(zr) + RND_HALF;
  end

  logic              s4_vld_q;
  item_t             s4_it_q;
  logic [FRAC_W-1:0] s4_fx_q;
  logic [ADDR_W-1:0] s4_addr_q [4];
  logic [WGT_W-1:0]  s4_wyz_q  [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_vld_q <= 1'b0;
    end else if (adv) begin
      s4_vld_q <= s3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s4_it_q <= s3_it_q;
      s4_fx_q <= mx[2*FRAC_W-1:FRAC_W];
      for (int c = 0; c < 4; c++) begin
        s4_addr_q[c] <= ADDR_W'(lin[c]);
        s4_wyz_q[c]  <= wp[c][FRAC_W+WGT_W-1:FRAC_W];
      end
    end
  end

  // Stage 5: sample memories and the eight corner weights. Weight index is
  // corner plus four times the plane.
  logic [WGT_W-1:0] wx [2];
  logic [MUL_W-1:0] wq [8];
  logic             wr_ok;
  logic [SMP_W-1:0] rd [2][4];

  always_comb begin
    wx[0] = WGT_ONE - {1'b0, s4_fx_q};
    wx[1] = {1'b0, s4_fx_q};
    for (int q = 0; q < 2; q++) begin
      for (int c = 0; c < 4; c++) begin
        wq[4*q+c] = MUL_W'(wx[q]) * MUL_W'(s4_wyz_q[c]) + RND_HALF;
      end
    end
    wr_ok = adv && s4_vld_q && !s4_it_q.smp &&
            (int'(s4_it_q.entry) < MAX_PLANE_CELLS);
  end

  for (genvar p = 0; p < 2; p++) begin : g_plane
    logic we;
    assign we = wr_ok && (s4_it_q.plane == p[0]);

    tps_ram #(
      .Width (SMP_W),
      .Depth (MAX_PLANE_CELLS)
    ) u_ram_lo (
      .clk_i     (clk_i),
      .we_i      (we),
      .waddr_i   (ADDR_W'(s4_it_q.entry)),
      .wdata_i   (s4_it_q.wdata),
      .re_i      (adv),
      .raddr_a_i (s4_addr_q[0]),
      .raddr_b_i (s4_addr_q[1]),
      .rdata_a_o (rd[p][0]),
      .rdata_b_o (rd[p][1])
    );

    tps_ram #(
      .Width (SMP_W),
      .Depth (MAX_PLANE_CELLS)
    ) u_ram_hi (
      .clk_i     (clk_i),
      .we_i      (we),
      .waddr_i   (ADDR_W'(s4_it_q.entry)),
      .wdata_i   (s4_it_q.wdata),
      .re_i      (adv),
      .raddr_a_i (s4_addr_q[2]),
      .raddr_b_i (s4_addr_q[3]),
      .rdata_a_o (rd[p][2]),
      .rdata_b_o (rd[p][3])
    );
  end

  logic             s5_vld_q;
  item_t            s5_it_q;
  logic [WGT_W-1:0] s5_w_q [8];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_vld_q <= 1'b0;
    end else if (adv) begin
      s5_vld_q <= s4_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s5_it_q <= s4_it_q;
      for (int i = 0; i < 8; i++) begin
        s5_w_q[i] <= wq[i][FRAC_W+WGT_W-1:FRAC_W];
      end
    end
  end

  // Stage 6: weighted samples, component 0 is u, 1 is v, 2 is w.
  logic signed [PROD_W-1:0] prod_d [8][3];
  vel_t                     smp    [8][3];

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      for (int j = 0; j < 3; j++) begin
        smp[i][j]    = rd[i/4][i%4][(3-j)*VEL_WIDTH-1 -: VEL_WIDTH];
        prod_d[i][j] = $signed({1'b0, s5_w_q[i]}) * smp[i][j];
      end
    end
  end

  logic                     s6_vld_q;
  logic                     s6_smp_q;
  logic                     s6_oob_q;
  logic signed [PROD_W-1:0] s6_prod_q [8][3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s6_vld_q <= 1'b0;
    end else if (adv) begin
      s6_vld_q <= s5_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s6_smp_q  <= s5_it_q.smp;
      s6_oob_q  <= s5_it_q.oob;
      s6_prod_q <= prod_d;
    end
  end

  // Stage 7: one partial sum per plane.
  logic signed [SUM_W-1:0] half_d [2][3];

  always_comb begin
    for (int q = 0; q < 2; q++) begin
      for (int j = 0; j < 3; j++) begin
        half_d[q][j] = SUM_W'(s6_prod_q[4*q][j]) + SUM_W'(s6_prod_q[4*q+1][j]) +
                       SUM_W'(s6_prod_q[4*q+2][j]) + SUM_W'(s6_prod_q[4*q+3][j]);
      end
    end
  end

  logic                    s7_vld_q;
  logic                    s7_smp_q;
  logic                    s7_oob_q;
  logic signed [SUM_W-1:0] s7_half_q [2][3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s7_vld_q <= 1'b0;
    end else if (adv) begin
      s7_vld_q <= s6_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s7_smp_q  <= s6_smp_q;
      s7_oob_q  <= s6_oob_q;
      s7_half_q <= half_d;
    end
  end

  // Final sum, round half up to Q5.10, saturate; zero outside the box.
  logic signed [SUM_W-1:0] tot [3];
  logic signed [RND_W-1:0] rnd [3];
  logic signed [RND_W-1:0] vmax, vmin;
  vel_t                    vel_d [3];

  always_comb begin
    vmax = RND_W'((1 << (VEL_WIDTH - 1)) - 1);
    vmin = -vmax - RND_W'(1);
    for (int j = 0; j < 3; j++) begin
      tot[j] = s7_half_q[0][j] + s7_half_q[1][j] + SUM_W'(RND_HALF);
      rnd[j] = tot[j][SUM_W-1:FRAC_W];
      if (s7_oob_q) begin
        vel_d[j] = '0;
      end else if (rnd[j] > vmax) begin
        vel_d[j] = vmax[VEL_WIDTH-1:0];
      end else if (rnd[j] < vmin) begin
        vel_d[j] = vmin[VEL_WIDTH-1:0];
      end else begin
        vel_d[j] = rnd[j][VEL_WIDTH-1:0];
      end
    end
  end

  logic oob_q;
  vel_t u_q, v_q, w_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= s7_vld_q && s7_smp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      oob_q <= s7_oob_q;
      u_q   <= vel_d[0];
      v_q   <= vel_d[1];
      w_q   <= vel_d[2];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_of_box_o = oob_q;
  assign u_out_o      = u_q;
  assign v_out_o      = v_q;
  assign w_out_o      = w_q;

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps

// Bench for the two-plane periodic velocity sampler.
// An initial block lays out the run in phases. Each phase programs the box
// geometry while the block is idle, fills every grid entry that a sample can
// read in both planes, and then queues sample and write beats. A clocked
// driver offers the queued beats, and a clocked monitor mirrors every
// accepted beat into a bit-accurate model of the sampler. The monitor then
// compares each result beat against the oldest expected result.
module tb_top;
  import tps_pkg::*;

  localparam int ENTRY_SPAN    = 2 * MAX_PLANE_CELLS;
  localparam int DRAIN_CYCLES  = 60;
  localparam int WATCHDOG_MAX  = 3000;
  localparam int HOLD_CYCLES   = 400;
  localparam int RANDOM_BEATS  = 80;

  typedef struct {
    op_e               op;
    logic              plane;
    logic [ENTRY_W-1:0] entry;
    vel_t              u;
    vel_t              v;
    vel_t              w;
    logic signed [POS_W-1:0] px;
    logic signed [POS_W-1:0] py;
    logic signed [POS_W-1:0] pz;
  } beat_t;

  typedef struct {
    logic oob;
    vel_t u;
    vel_t v;
    vel_t w;
  } velocity_t;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  logic op_i;
  logic plane_i;
  logic [ENTRY_W-1:0] entry_index_i;
  vel_t u_in_i, v_in_i, w_in_i;
  logic signed [POS_W-1:0] pos_x_i, pos_y_i, pos_z_i;
  logic out_valid_o;
  logic out_stall_i;
  logic out_of_box_o;
  vel_t u_out_o, v_out_o, w_out_o;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [CIDX_W-1:0] cfg_index_i;
  logic [LEN_W-1:0] cfg_data_i;

  turbulence_plane_sampler u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .op_i          (op_i),
    .plane_i       (plane_i),
    .entry_index_i (entry_index_i),
    .u_in_i        (u_in_i),
    .v_in_i        (v_in_i),
    .w_in_i        (w_in_i),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .pos_z_i       (pos_z_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_of_box_o  (out_of_box_o),
    .u_out_o       (u_out_o),
    .v_out_o       (v_out_o),
    .w_out_o       (w_out_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Model copy of the geometry registers and of both planes.
  longint unsigned geo_len_x, geo_len_y, geo_len_z;
  longint unsigned geo_inv_x, geo_inv_y, geo_inv_z;
  int unsigned     geo_cells_y, geo_cells_z;
  vel_t            u_mem [ENTRY_SPAN];
  vel_t            v_mem [ENTRY_SPAN];
  vel_t            w_mem [ENTRY_SPAN];

  beat_t     pending_beats [$];
  velocity_t expected_velocities [$];
  beat_t     cur_beat;
  logic      in_taken;
  logic      calm;
  logic      hold_req;
  logic      hold_done;
  int        hold_left;
  int        error_count;
  int        idle_cycles;
  int        n_samples, n_writes, n_outside, n_phases;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Periodic cell lookup: integer part of pos*inv is the left index, bits
  // 31..16 are the Q0.16 fraction.
  function automatic void find_cell(input longint unsigned pos, input longint unsigned inv,
                                    input int unsigned n, output int unsigned il,
                                    output int unsigned ir, output longint unsigned frac);
    longint unsigned prod;
    prod = pos * inv;
    il   = int'((prod >> 32) % n);
    ir   = il + 1;
    if (ir >= n) ir = 0;
    frac = (prod >> 16) & 64'hFFFF;
  endfunction

  // A coordinate is shifted by half the box length; the far face folds to 0.
  function automatic logic in_box(input logic signed [POS_W-1:0] raw,
                                  input longint unsigned len, output longint unsigned pos);
    longint c;
    c = longint'(raw) + longint'(len >> 1);
    if (c < 0 || c > longint'(len)) return 1'b0;
    pos = (c == longint'(len)) ? 0 : longint'(c);
    return 1'b1;
  endfunction

  function automatic vel_t round_saturate(input longint acc);
    longint r;
    r = (acc + 32768) >>> 16;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return vel_t'(r);
  endfunction

  function automatic velocity_t interpolate_velocity(input beat_t b);
    velocity_t res;
    longint unsigned lx, ly, lz, py, pz, px, fy, fz, fx, wx, wt;
    longint unsigned wyz [4];
    int unsigned ny, nz, jl, jr, kl, kr, dl, dr, a;
    int unsigned addr [4];
    longint sx, acc_u, acc_v, acc_w;
    lx = geo_len_x ? geo_len_x : 1;
    ly = geo_len_y ? geo_len_y : 1;
    lz = geo_len_z ? geo_len_z : 1;
    ny = geo_cells_y ? geo_cells_y : 1;
    nz = geo_cells_z ? geo_cells_z : 1;
    res = '{oob: 1'b1, u: '0, v: '0, w: '0};
    if (!in_box(b.py, ly, py)) return res;
    if (!in_box(b.pz, lz, pz)) return res;
    sx = longint'(b.px) % longint'(lx);
    if (sx < 0) sx += longint'(lx);
    px = sx;
    find_cell(py, geo_inv_y, ny, jl, jr, fy);
    find_cell(pz, geo_inv_z, nz, kl, kr, fz);
    find_cell(px, geo_inv_x, 1, dl, dr, fx);
    addr[0] = (jl * nz + kl) % MAX_PLANE_CELLS;
    addr[1] = (jr * nz + kl) % MAX_PLANE_CELLS;
    addr[2] = (jr * nz + kr) % MAX_PLANE_CELLS;
    addr[3] = (jl * nz + kr) % MAX_PLANE_CELLS;
    wyz[0] = ((65536 - fy) * (65536 - fz) + 32768) >> 16;
    wyz[1] = (fy * (65536 - fz) + 32768) >> 16;
    wyz[2] = (fy * fz + 32768) >> 16;
    wyz[3] = ((65536 - fy) * fz + 32768) >> 16;
    acc_u = 0;
    acc_v = 0;
    acc_w = 0;
    for (int q = 0; q < 2; q++) begin
      wx = q ? fx : 65536 - fx;
      for (int c = 0; c < 4; c++) begin
        wt = (wx * wyz[c] + 32768) >> 16;
        a  = q * MAX_PLANE_CELLS + addr[c];
        acc_u += longint'(wt) * longint'(u_mem[a]);
        acc_v += longint'(wt) * longint'(v_mem[a]);
        acc_w += longint'(wt) * longint'(w_mem[a]);
      end
    end
    res.oob = 1'b0;
    res.u   = round_saturate(acc_u);
    res.v   = round_saturate(acc_v);
    res.w   = round_saturate(acc_w);
    return res;
  endfunction

  // Driver: presents the next queued beat at the falling edge once the
  // current one has been taken.
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (pending_beats.size() > 0 && (calm || $urandom_range(99) >= 7)) begin
        cur_beat      = pending_beats.pop_front();
        in_valid_i    <= 1'b1;
        op_i          <= cur_beat.op;
        plane_i       <= cur_beat.plane;
        entry_index_i <= cur_beat.entry;
        u_in_i        <= cur_beat.u;
        v_in_i        <= cur_beat.v;
        w_in_i        <= cur_beat.w;
        pos_x_i       <= cur_beat.px;
        pos_y_i       <= cur_beat.py;
        pos_z_i       <= cur_beat.pz;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off on request so the
  // pipeline fills and pushes back on the input.
  always @(negedge clk_i) begin
    if (hold_req && !hold_done) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left   = hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= !calm && ($urandom_range(99) < 7);
    end
  end

  // Monitor: model updates on accepted beats, checks result beats, and
  // keeps the watchdog.
  always @(posedge clk_i) begin
    beat_t     b;
    velocity_t exp_v;
    logic      active;
    if (rst_ni) begin
      active   = 1'b0;
      in_taken <= in_valid_i && !in_stall_o;
      if (cfg_valid_i && cfg_ready_o) begin
        active = 1'b1;
        case (cfg_idx_e'(cfg_index_i))
          CFG_LEN_X:      geo_len_x   = cfg_data_i;
          CFG_LEN_Y:      geo_len_y   = cfg_data_i;
          CFG_LEN_Z:      geo_len_z   = cfg_data_i;
          CFG_INV_CELL_X: geo_inv_x   = cfg_data_i;
          CFG_INV_CELL_Y: geo_inv_y   = cfg_data_i;
          CFG_INV_CELL_Z: geo_inv_z   = cfg_data_i;
          CFG_CELLS_Y:    geo_cells_y = cfg_data_i[CNT_W-1:0];
          CFG_CELLS_Z:    geo_cells_z = cfg_data_i[CNT_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_o) begin
        active = 1'b1;
        b = cur_beat;
        if (b.op == OP_WRITE) begin
          n_writes++;
          if (b.entry < MAX_PLANE_CELLS) begin
            u_mem[b.plane * MAX_PLANE_CELLS + b.entry] = b.u;
            v_mem[b.plane * MAX_PLANE_CELLS + b.entry] = b.v;
            w_mem[b.plane * MAX_PLANE_CELLS + b.entry] = b.w;
          end
        end else begin
          n_samples++;
          exp_v = interpolate_velocity(b);
          if (exp_v.oob) n_outside++;
          expected_velocities.push_back(exp_v);
        end
      end
      if (out_valid_o && !out_stall_i) begin
        active = 1'b1;
        if (expected_velocities.size() == 0) begin
          $error("unexpected result beat");
          error_count++;
        end else begin
          exp_v = expected_velocities.pop_front();
          if (out_of_box_o !== exp_v.oob) begin
            $error("out_of_box expected %0d actual %0d", exp_v.oob, out_of_box_o);
            error_count++;
          end
          if (u_out_o !== exp_v.u) begin
            $error("u_out expected %0d actual %0d", exp_v.u, u_out_o);
            error_count++;
          end
          if (v_out_o !== exp_v.v) begin
            $error("v_out expected %0d actual %0d", exp_v.v, v_out_o);
            error_count++;
          end
          if (w_out_o !== exp_v.w) begin
            $error("w_out expected %0d actual %0d", exp_v.w, w_out_o);
            error_count++;
          end
        end
      end
      idle_cycles = active ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_MAX) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  task automatic write_reg(input cfg_idx_e idx, input longint unsigned value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value[LEN_W-1:0];
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_geometry(input longint unsigned lx, ly, lz, ix, iy, iz,
                              input int unsigned ny, nz);
    write_reg(CFG_LEN_X, lx);
    write_reg(CFG_LEN_Y, ly);
    write_reg(CFG_LEN_Z, lz);
    write_reg(CFG_INV_CELL_X, ix);
    write_reg(CFG_INV_CELL_Y, iy);
    write_reg(CFG_INV_CELL_Z, iz);
    write_reg(CFG_CELLS_Y, ny);
    write_reg(CFG_CELLS_Z, nz);
  endtask

  // Waits until every queued beat is taken and every result is back, then
  // lets the pipeline run empty of writes too.
  task automatic wait_drained();
    do @(posedge clk_i);
    while (!(pending_beats.size() == 0 && !in_valid_i && expected_velocities.size() == 0));
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic queue_write(input logic plane, input int unsigned entry,
                             input vel_t u, input vel_t v, input vel_t w);
    beat_t b;
    b = '{op: OP_WRITE, plane: plane, entry: entry[ENTRY_W-1:0], u: u, v: v, w: w,
          px: $urandom, py: $urandom, pz: $urandom};
    pending_beats.push_back(b);
  endtask

  task automatic queue_sample(input logic signed [POS_W-1:0] px, py, pz);
    beat_t b;
    b = '{op: OP_SAMPLE, plane: $urandom_range(1), entry: $urandom, u: $urandom,
          v: $urandom, w: $urandom, px: px, py: py, pz: pz};
    pending_beats.push_back(b);
  endtask

  // Every entry a sample can reach lies below cells_y * cells_z, so filling
  // that range in both planes keeps every read on written data.
  task automatic fill_planes();
    for (int p = 0; p < 2; p++)
      for (int e = 0; e < int'(geo_cells_y * geo_cells_z); e++)
        queue_write(p, e, $urandom, $urandom, $urandom);
  endtask

  // Mostly inside the box, some on or just past its faces, the rest anywhere.
  function automatic logic signed [POS_W-1:0] pick_coord(input longint unsigned len);
    int unsigned sel;
    longint c;
    sel = $urandom_range(99);
    if (sel < 75) c = $urandom_range(int'(len), 0);
    else if (sel < 80) c = $urandom_range(1) ? longint'(len) : 0;
    else if (sel < 85) c = $urandom_range(1) ? longint'(len) + 1 : -1;
    else return $urandom;
    return POS_W'(c - longint'(len >> 1));
  endfunction

  task automatic queue_random(input int count);
    int unsigned n;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 20) begin
        n = $urandom_range(99) < 60 ? $urandom_range(geo_cells_y * geo_cells_z - 1)
                                    : $urandom_range(MAX_PLANE_CELLS - 1);
        queue_write($urandom_range(1), n, $urandom, $urandom, $urandom);
      end else begin
        queue_sample($urandom, pick_coord(geo_len_y), pick_coord(geo_len_z));
      end
    end
  endtask

  task automatic run_phase(input longint unsigned lx, ly, lz, ix, iy, iz,
                           input int unsigned ny, nz);
    set_geometry(lx, ly, lz, ix, iy, iz, ny, nz);
    n_phases++;
    fill_planes();
    queue_random(RANDOM_BEATS);
    wait_drained();
  endtask

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    op_i          = 1'b0;
    plane_i       = 1'b0;
    entry_index_i = '0;
    u_in_i        = '0;
    v_in_i        = '0;
    w_in_i        = '0;
    pos_x_i       = '0;
    pos_y_i       = '0;
    pos_z_i       = '0;
    out_stall_i   = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    in_taken      = 1'b0;
    calm          = 1'b0;
    hold_req      = 1'b0;
    hold_done     = 1'b0;
    hold_left     = 0;
    error_count   = 0;
    idle_cycles   = 0;
    n_samples     = 0;
    n_writes      = 0;
    n_outside     = 0;
    n_phases      = 0;
    geo_len_x     = LEN_RST;
    geo_len_y     = LEN_RST;
    geo_len_z     = LEN_RST;
    geo_inv_x     = LEN_RST;
    geo_inv_y     = LEN_RST;
    geo_inv_z     = LEN_RST;
    geo_cells_y   = CNT_RST;
    geo_cells_z   = CNT_RST;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset geometry: one cell per unit of length, so every point inside the
    // box lands on the first two rows and columns of the 64 by 64 grid. The
    // directed writes below cover exactly those entries in both planes.
    // Full-scale samples around the origin corner so the blend saturates.
    for (int e = 0; e < 2; e++) begin
      queue_write(0, e, 16'sh7FFF, -16'sh8000, 16'sh7FFF);
      queue_write(1, e, 16'sh7FFF, -16'sh8000, 16'sh7FFF);
      queue_write(0, 64 + e, 16'sh7FFF, -16'sh8000, -16'sh8000);
      queue_write(1, 64 + e, 16'sh7FFF, -16'sh8000, -16'sh8000);
    end
    queue_sample(0, -32768 + 16'h4000, -32768 + 16'h4000);
    queue_sample(32'sh7FFFFFFF, -32768 + 16'h8000, -32768 + 16'hC000);
    queue_sample(-32'sh80000000, -32768, -32768);
    // Both far faces fold back onto the first grid point.
    queue_sample(-1, 32768, 32768);
    queue_sample(16'h8000, 32768, -32768);
    // Just outside each face, and the extremes of the position fields.
    queue_sample(0, 32769, 0);
    queue_sample(0, -32769, 0);
    queue_sample(0, 0, 32769);
    queue_sample(0, 0, -32769);
    queue_sample(0, 32'sh7FFFFFFF, 0);
    queue_sample(0, 0, -32'sh80000000);
    queue_sample(-32'sh80000000, 32'sh7FFFFFFF, -32'sh80000000);
    // Last entry of the store in both planes, then samples by the far corner.
    queue_write(0, MAX_PLANE_CELLS - 1, -16'sh8000, 16'sh7FFF, 16'sh0001);
    queue_write(1, MAX_PLANE_CELLS - 1, 16'sh7FFF, -16'sh8000, -16'sh0001);
    queue_sample(32767, 32767, 32767);
    queue_sample(-65535, 32000, 32000);
    wait_drained();

    queue_random(RANDOM_BEATS);
    wait_drained();

    // Longest boxes with the coarsest grid, then the tiniest box with the
    // finest spacing.
    run_phase(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 1, 1, 1, 2, 2);
    run_phase(1, 1, 1, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32, 2);

    // No idling on either side for one whole phase.
    calm = 1'b1;
    run_phase(4 << 16, 4 << 16, 8 << 16, 1 << 16, 1 << 16, 1 << 16, 4, 8);
    calm = 1'b0;

    // Long receiver hold-off while the sender keeps offering beats.
    hold_req = 1'b1;
    run_phase(3 << 16, 5 << 16, 2 << 16, 3 << 16, 1 << 16, 7 << 15, 5, 3);

    for (int i = 0; i < 4; i++)
      run_phase($urandom_range(1 << 22, 1), $urandom_range(1 << 22, 1),
                $urandom_range(1 << 22, 1), $urandom_range(1 << 22, 1),
                $urandom_range(1 << 20, 1 << 10), $urandom_range(1 << 20, 1 << 10),
                $urandom_range(9, 2), $urandom_range(9, 2));

    wait_drained();
    $display("covered %0d phases: %0d sample beats (%0d outside the box), %0d write beats",
             n_phases, n_samples, n_outside, n_writes);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/tps_pkg.sv
src/tps_ram.sv
src/turbulence_plane_sampler.sv
bench/tb_top.sv
